>>> hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Shared types, field widths and character codes for the line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int LEN_W      = 13;
    localparam int IDX_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int MAX_LENGTH = 4096;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Characters with a meaning to the editor.
    localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] descriptor;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic              echo_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic              store_valid;
        logic [IDX_W-1:0]  store_index;
        logic [BYTE_W-1:0] store_byte;
        logic              done_res;
        logic [LEN_W-1:0]  count;
        logic              error;
        logic              last;
    } result_t;

endpackage

>>> hdl/cle_in_reg.sv
// ----------------------------------------------------------------------------
// Line editor input register
// Holds one input item until the editor has issued all of its results.
// ----------------------------------------------------------------------------
module cle_in_reg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cle_pkg::IN_DATA_W-1:0]  in_data,
    input  logic                           in_op,
    output logic                           item_valid,
    output cle_pkg::item_t                 item,
    input  logic                           item_done
);

    logic           valid_reg;
    cle_pkg::item_t item_reg;

    // A new item may enter in the same cycle the held one retires.
    assign in_ready   = !valid_reg || item_done;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op         <= in_op;
            item_reg.descriptor <= in_data[7:0];
            item_reg.length     <= in_data[20:8];
            item_reg.rx_byte    <= in_data[28:21];
        end
    end

endmodule

>>> hdl/cle_editor.sv
// ----------------------------------------------------------------------------
// Line editor core
// Keeps the request state and issues the results of the held item, one per
// cycle while res_ready is high, and updates the state as the item retires.
// ----------------------------------------------------------------------------
module cle_editor
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  cle_pkg::item_t   item,
    output logic             item_done,
    output logic             res_valid,
    output cle_pkg::result_t res,
    input  logic             res_ready
);

    logic                      open_reg;
    logic                      open_next;
    logic [cle_pkg::LEN_W-1:0] count_reg;
    logic [cle_pkg::LEN_W-1:0] count_next;
    logic [cle_pkg::LEN_W-1:0] limit_reg;
    logic [cle_pkg::LEN_W-1:0] limit_next;
    logic [1:0]                phase_reg;
    logic [1:0]                phase_next;

    logic [1:0]                n_res;
    logic [cle_pkg::LEN_W-1:0] len_sat;
    logic [cle_pkg::LEN_W-1:0] count_inc;
    logic                      last_phase;
    logic                      advance;

    assign count_inc = count_reg + 1'b1;
    assign len_sat   = (item.length > cle_pkg::LEN_W'(cle_pkg::MAX_LENGTH))
                     ? cle_pkg::LEN_W'(cle_pkg::MAX_LENGTH) : item.length;

    always_comb
    begin
        n_res      = 2'd0;
        res        = '0;
        open_next  = open_reg;
        count_next = count_reg;
        limit_next = limit_reg;

        if (item.op == cle_pkg::OP_START)
        begin
            open_next  = 1'b0;
            count_next = '0;
            limit_next = '0;
            n_res      = 2'd1;
            res.done_res = 1'b1;
            res.last     = 1'b1;
            if (item.descriptor != '0)
            begin
                res.error = 1'b1;
            end
            else if (len_sat != '0)
            begin
                n_res      = 2'd0;
                limit_next = len_sat;
                open_next  = 1'b1;
            end
        end
        else if (open_reg)
        begin
            n_res = 2'd1;
            case (item.rx_byte)
                cle_pkg::CH_EOT:
                begin
                    open_next    = 1'b0;
                    res.done_res = 1'b1;
                    res.count    = count_reg;
                    res.last     = 1'b1;
                end
                cle_pkg::CH_BS:
                begin
                    n_res          = 2'd3;
                    count_next     = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                    res.echo_valid = 1'b1;
                    res.echo_byte  = (phase_reg == 2'd1) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
                    res.last       = (phase_reg == 2'd2);
                end
                cle_pkg::CH_LF:
                begin
                    count_next      = count_inc;
                    open_next       = 1'b0;
                    res.echo_valid  = 1'b1;
                    res.echo_byte   = cle_pkg::CH_LF;
                    res.store_valid = 1'b1;
                    res.store_index = count_reg[cle_pkg::IDX_W-1:0];
                    res.store_byte  = cle_pkg::CH_LF;
                    res.done_res    = 1'b1;
                    res.count       = count_inc;
                    res.last        = 1'b1;
                end
                cle_pkg::CH_CR:
                begin
                    n_res          = 2'd2;
                    count_next     = count_inc;
                    open_next      = 1'b0;
                    res.echo_valid = 1'b1;
                    if (phase_reg == 2'd0)
                    begin
                        // The CR echo carries the store of the newline.
                        res.echo_byte   = cle_pkg::CH_CR;
                        res.store_valid = 1'b1;
                        res.store_index = count_reg[cle_pkg::IDX_W-1:0];
                        res.store_byte  = cle_pkg::CH_LF;
                    end
                    else
                    begin
                        res.echo_byte = cle_pkg::CH_LF;
                        res.done_res  = 1'b1;
                        res.count     = count_inc;
                        res.last      = 1'b1;
                    end
                end
                default:
                begin
                    count_next      = count_inc;
                    res.echo_valid  = 1'b1;
                    res.echo_byte   = item.rx_byte;
                    res.store_valid = 1'b1;
                    res.store_index = count_reg[cle_pkg::IDX_W-1:0];
                    res.store_byte  = item.rx_byte;
                    res.last        = 1'b1;
                    if (count_inc >= limit_reg)
                    begin
                        open_next    = 1'b0;
                        res.done_res = 1'b1;
                        res.count    = count_inc;
                    end
                end
            endcase
        end
    end

    assign last_phase = (n_res == 2'd0) || (phase_reg == n_res - 2'd1);
    assign res_valid  = item_valid && (n_res != 2'd0);
    assign advance    = item_valid && ((n_res == 2'd0) || res_ready);
    assign item_done  = advance && last_phase;
    assign phase_next = item_done ? 2'd0 : phase_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            limit_reg <= '0;
            phase_reg <= 2'd0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
            end
            if (item_done)
            begin
                open_reg  <= open_next;
                count_reg <= count_next;
                limit_reg <= limit_next;
            end
        end
    end

endmodule

>>> hdl/cle_out_reg.sv
// ----------------------------------------------------------------------------
// Line editor output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module cle_out_reg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_valid,
    input  cle_pkg::result_t               res,
    output logic                           res_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cle_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_last
);

    logic             valid_reg;
    cle_pkg::result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_last  = res_reg.last;
    assign out_data  = {3'b000, res_reg.error, res_reg.count, res_reg.done_res,
                        res_reg.store_byte, res_reg.store_index, res_reg.store_valid,
                        res_reg.echo_byte, res_reg.echo_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> hdl/console_line_editor.sv
// ----------------------------------------------------------------------------
// Console line editor
// Canonical line editing of received serial bytes for console read requests.
// ----------------------------------------------------------------------------
// A start transfer (tuser 0) opens a read request; received bytes (tuser 1)
// are then echoed and stored until EOT, newline, carriage return or the
// requested length ends the request. The editor core issues one result per
// cycle while the output side accepts them: one result for most items, none
// for a start that opens a request or a byte outside one, two for CR and
// three for backspace. An input register and an output register part the two
// sides, so one new item can be held while a result still waits downstream.
module console_line_editor
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // descriptor[7:0], length[20:8], rx_byte[28:21], zero fill
    input  logic [cle_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // echo_valid[0], echo_byte[8:1], store_valid[9], store_index[21:10],
    // store_byte[29:22], done_res[30], count[43:31], error[44], zero fill
    output logic [cle_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    logic             item_valid;
    cle_pkg::item_t   item;
    logic             item_done;
    logic             res_valid;
    cle_pkg::result_t res;
    logic             res_ready;

    cle_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_op      (s_axis_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_done  (item_done)
    );

    cle_editor u_editor
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_done  (item_done),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    cle_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
